### sv/dlps_pkg.sv
package dlps_pkg;

	localparam int DelayDepth  = 8192;
	localparam int SampleBits  = 24;
	localparam int FadeEntries = 1024;

	localparam int PincBits    = 29;
	localparam int WinBits     = 21;
	localparam int MixBits     = 16;
	localparam int GainBits    = 15;
	localparam int CfgAddrBits = 5;
	localparam int CfgDataBits = 32;

	typedef enum logic [2:0] {
		REG_PINC = 3'd0,
		REG_WIN  = 3'd1,
		REG_UP   = 3'd2,
		REG_EN   = 3'd3,
		REG_MIX  = 3'd4,
		REG_GAIN = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [PincBits-1:0] phase_increment;
		logic [WinBits-1:0]  window_length;
		logic                shift_up;
		logic                shift_enable;
		logic [MixBits-1:0]  mix_level;
		logic [GainBits-1:0] gain_level;
	} cfg_t;

	// sin^2(pi*i/n) in Q1.15 through a Q30 Taylor series, n = 2**lg_n
	function automatic logic [15:0] fade_entry(input int unsigned i, input int unsigned lg_n);
		longint unsigned n;
		longint unsigned x;
		longint unsigned a;
		longint unsigned a2;
		longint unsigned t;
		longint unsigned s;
		longint unsigned v;
		longint unsigned one;
		n   = 64'd1 << lg_n;
		one = 64'd1 << 30;
		x   = (64'(i) <= n - 64'(i)) ? 64'(i) : n - 64'(i);
		a   = (64'd3373259426 * x) >> lg_n;
		a2  = (a * a) >> 30;
		t   = one - a2 / 110;
		t   = one - ((a2 * t) >> 30) / 72;
		t   = one - ((a2 * t) >> 30) / 42;
		t   = one - ((a2 * t) >> 30) / 20;
		t   = one - ((a2 * t) >> 30) / 6;
		s   = (a * t) >> 30;
		if (s > one) begin
			s = one;
		end
		v = (s * s + (64'd1 << 44)) >> 45;
		if (v > 64'd32768) begin
			v = 64'd32768;
		end
		return v[15:0];
	endfunction

endpackage

### sv/dlps_ram.sv
module dlps_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### sv/dlps_cfg.sv
module dlps_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [dlps_pkg::CfgAddrBits-1:0]    paddr,
	input  logic [dlps_pkg::CfgDataBits-1:0]    pwdata,
	output logic [dlps_pkg::CfgDataBits-1:0]    prdata,
	output logic                                pready,
	output dlps_pkg::cfg_t                      cfg
);
	import dlps_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[CfgAddrBits-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_increment <= '0;
			cfg_q.window_length   <= WinBits'(552960);
			cfg_q.shift_up        <= 1'b1;
			cfg_q.shift_enable    <= 1'b0;
			cfg_q.mix_level       <= MixBits'(32768);
			cfg_q.gain_level      <= GainBits'(4096);
		end else if (wr_en) begin
			case (idx)
				REG_PINC: cfg_q.phase_increment <= pwdata[PincBits-1:0];
				REG_WIN:  cfg_q.window_length   <= pwdata[WinBits-1:0];
				REG_UP:   cfg_q.shift_up        <= pwdata[0];
				REG_EN:   cfg_q.shift_enable    <= pwdata[0];
				REG_MIX:  cfg_q.mix_level       <= pwdata[MixBits-1:0];
				REG_GAIN: cfg_q.gain_level      <= pwdata[GainBits-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_PINC: prdata = CfgDataBits'(cfg_q.phase_increment);
			REG_WIN:  prdata = CfgDataBits'(cfg_q.window_length);
			REG_UP:   prdata = CfgDataBits'(cfg_q.shift_up);
			REG_EN:   prdata = CfgDataBits'(cfg_q.shift_enable);
			REG_MIX:  prdata = CfgDataBits'(cfg_q.mix_level);
			REG_GAIN: prdata = CfgDataBits'(cfg_q.gain_level);
			default:  prdata = '0;
		endcase
	end

endmodule

### sv/delay_line_pitch_shifter.sv
// Channel   | Direction | Beat contents
// s_*       | in        | tdata: sample_in (signed), zero padded to bytes
// m_*       | out       | tdata: sample_out (signed), zero padded to bytes
// APB       | in/out    | six registers at byte address 4*i, pready tied high
//
// A shifted sample steps through the delay, tap read, crossfade, mix and gain states
// on its way to the result register; a bypassed sample goes straight to the gain state.
// The four tap reads share the single read port of the delay memory.
// Reset clears control state; entries of the delay memory never written read as zero
// through a fill flag, so no clearing pass is needed. DELAY_DEPTH and FADE_ENTRIES
// must be powers of two. A waiting result blocks the next input beat; the
// sequencer holds in its last step only while the result register is still full.
module delay_line_pitch_shifter #(
	parameter int DELAY_DEPTH  = dlps_pkg::DelayDepth,
	parameter int SAMPLE_BITS  = dlps_pkg::SampleBits,
	parameter int FADE_ENTRIES = dlps_pkg::FadeEntries
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,   // [SAMPLE_BITS-1:0] sample_in
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_tdata,   // [SAMPLE_BITS-1:0] sample_out
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [dlps_pkg::CfgAddrBits-1:0]     paddr,
	input  logic [dlps_pkg::CfgDataBits-1:0]     pwdata,
	output logic [dlps_pkg::CfgDataBits-1:0]     prdata,
	output logic                                 pready
);
	import dlps_pkg::*;

	localparam int DW = ((SAMPLE_BITS+7)/8)*8;
	localparam int AB = $clog2(DELAY_DEPTH);   // memory index
	localparam int WB = AB + 8;                // window and read position, 8 fraction bits
	localparam int FB = $clog2(FADE_ENTRIES);
	localparam int TB = SAMPLE_BITS + 10;      // tap, shifted and mixed values
	localparam int XB = TB + 17;               // products against Q1.15 weights
	localparam logic [31:0] WLO = 32'(32*256);
	localparam logic [31:0] WHI = 32'((DELAY_DEPTH-4)*256);
	localparam logic signed [XB:0] SAT_HI = (XB+1)'((64'sd1 <<< (SAMPLE_BITS-1)) - 64'sd1);
	localparam logic signed [XB:0] SAT_LO = (XB+1)'(-(64'sd1 <<< (SAMPLE_BITS-1)));

	typedef logic [15:0] fade_rom_t [FADE_ENTRIES];

	function automatic fade_rom_t build_fade();
		fade_rom_t r;
		for (int i = 0; i < FADE_ENTRIES; i++) begin
			r[i] = fade_entry(i, FB);
		end
		return r;
	endfunction

	localparam fade_rom_t FADE_ROM = build_fade();

	typedef enum logic [13:0] {
		ST_IDLE  = 14'b00000000000001,
		ST_DLY1  = 14'b00000000000010,
		ST_DLY2  = 14'b00000000000100,
		ST_RA0   = 14'b00000000001000,
		ST_RA1   = 14'b00000000010000,
		ST_RA2   = 14'b00000000100000,
		ST_RA3   = 14'b00000001000000,
		ST_TAP2  = 14'b00000010000000,
		ST_FADE1 = 14'b00000100000000,
		ST_FADE2 = 14'b00001000000000,
		ST_MIX1  = 14'b00010000000000,
		ST_MIX2  = 14'b00100000000000,
		ST_GAIN  = 14'b01000000000000,
		ST_OUT   = 14'b10000000000000
	} state_t;

	cfg_t   cfg;
	state_t state_q;

	logic [AB-1:0]                wp_q;
	logic                         wrapped_q;
	logic [31:0]                  phase_q;
	logic [WB-1:0]                win_q;
	logic [WB-1:0]                d_q;
	logic [WB-1:0]                pos1_q;
	logic [WB-1:0]                pos2_q;
	logic [15:0]                  fade_q;
	logic signed [SAMPLE_BITS-1:0] dry_q;
	logic signed [TB-1:0]         p_q;
	logic signed [TB-1:0]         t1_q;
	logic signed [TB-1:0]         t2_q;
	logic signed [TB-1:0]         shifted_q;
	logic signed [TB-1:0]         mixed_q;
	logic signed [XB-1:0]         x_q;
	logic signed [XB:0]           res_q;
	logic                         rvalid_s1;
	logic                         m_tvalid_q;
	logic [SAMPLE_BITS-1:0]       out_q;

	logic                         accept;
	logic                         out_load;
	logic signed [SAMPLE_BITS-1:0] s_sample;
	logic [31:0]                  w32;
	logic [31:0]                  wclamp;
	logic [31:0]                  ph_sel;
	logic [32:0]                  f33;
	logic [32+WB:0]               dprod;
	logic [WB-1:0]                wp8;
	logic [AB-1:0]                raddr;
	logic [SAMPLE_BITS-1:0]       rdata;
	logic signed [SAMPLE_BITS-1:0] m_s;
	logic [7:0]                   frac;
	logic [8:0]                   coef;
	logic signed [TB-1:0]         tap_sum;
	logic [15:0]                  mix_c;
	logic signed [TB-1:0]         mul_a;
	logic [15:0]                  mul_b;
	logic signed [XB-1:0]         mul_p;
	logic signed [XB:0]           acc_sum;
	logic signed [XB:0]           acc_sh;
	logic signed [XB:0]           sat;

	dlps_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// one write per item at accept; four reads later, all on the single read port
	dlps_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (DELAY_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (accept),
		.waddr (wp_q),
		.wdata (s_sample),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign s_sample = $signed(s_tdata[SAMPLE_BITS-1:0]);
	assign out_load = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = DW'(out_q);

	// clamp the window into the usable span of the memory
	assign w32    = 32'(cfg.window_length);
	assign wclamp = (w32 < WLO) ? WLO : ((w32 > WHI) ? WHI : w32);

	// tap delay: phase fraction (or its complement when shifting up) times window
	assign ph_sel = (state_q == ST_DLY1) ? phase_q : phase_q + 32'h8000_0000;
	assign f33    = cfg.shift_up ? (33'h1_0000_0000 - {1'b0, ph_sel}) : {1'b0, ph_sel};
	assign dprod  = f33 * (33+WB)'(win_q);
	assign wp8    = {wp_q, 8'h00};

	always_comb begin
		case (state_q)
			ST_RA0:  raddr = pos1_q[WB-1:8];
			ST_RA1:  raddr = pos1_q[WB-1:8] + 1'b1;
			ST_RA2:  raddr = pos2_q[WB-1:8];
			ST_RA3:  raddr = pos2_q[WB-1:8] + 1'b1;
			default: raddr = '0;
		endcase
	end

	// linear interpolation, one memory word per cycle
	assign m_s     = rvalid_s1 ? $signed(rdata) : '0;
	assign frac    = (state_q == ST_RA1 || state_q == ST_RA2) ? pos1_q[7:0] : pos2_q[7:0];
	assign coef    = (state_q == ST_RA1 || state_q == ST_RA3) ? 9'd256 - {1'b0, frac}
	                                                          : {1'b0, frac};
	assign tap_sum = ((state_q == ST_RA2 || state_q == ST_TAP2) ? p_q : TB'(0))
	               + TB'(m_s * $signed({1'b0, coef}));

	// shared multiply for crossfade, mix and gain
	assign mix_c = (cfg.mix_level > 16'd32768) ? 16'd32768 : cfg.mix_level;

	always_comb begin
		case (state_q)
			ST_FADE1: begin
				mul_a = t1_q;
				mul_b = 16'd32768 - fade_q;
			end
			ST_FADE2: begin
				mul_a = t2_q;
				mul_b = fade_q;
			end
			ST_MIX1: begin
				mul_a = TB'($signed({dry_q, 8'h00}));
				mul_b = 16'd32768 - mix_c;
			end
			ST_MIX2: begin
				mul_a = shifted_q;
				mul_b = mix_c;
			end
			ST_GAIN: begin
				mul_a = mixed_q;
				mul_b = 16'(cfg.gain_level);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p   = mul_a * $signed({1'b0, mul_b});
	// round half up, then an arithmetic shift floors
	assign acc_sum = ((state_q == ST_FADE2 || state_q == ST_MIX2) ? (XB+1)'(x_q) : '0)
	               + (XB+1)'(mul_p)
	               + ((state_q == ST_GAIN) ? (XB+1)'(1 << 19) : (XB+1)'(1 << 14));
	assign acc_sh  = (state_q == ST_GAIN) ? (acc_sum >>> 20) : (acc_sum >>> 15);

	assign sat = (res_q > SAT_HI) ? SAT_HI : ((res_q < SAT_LO) ? SAT_LO : res_q);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			wp_q       <= '0;
			wrapped_q  <= 1'b0;
			phase_q    <= '0;
			m_tvalid_q <= 1'b0;
			rvalid_s1  <= 1'b0;
		end else begin
			// an entry counts as written once the pointer has reached it or has wrapped
			rvalid_s1 <= wrapped_q || (raddr <= wp_q);
			// raise on a new result, drop once the beat is taken
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cfg.shift_enable) begin
							phase_q <= phase_q + {{(32-PincBits){cfg.phase_increment[PincBits-1]}},
							                      cfg.phase_increment};
							state_q <= ST_DLY1;
						end else begin
							state_q <= ST_GAIN;
						end
					end
				end
				ST_DLY1:  state_q <= ST_DLY2;
				ST_DLY2:  state_q <= ST_RA0;
				ST_RA0:   state_q <= ST_RA1;
				ST_RA1:   state_q <= ST_RA2;
				ST_RA2:   state_q <= ST_RA3;
				ST_RA3:   state_q <= ST_TAP2;
				ST_TAP2:  state_q <= ST_FADE1;
				ST_FADE1: state_q <= ST_FADE2;
				ST_FADE2: state_q <= ST_MIX1;
				ST_MIX1:  state_q <= ST_MIX2;
				ST_MIX2:  state_q <= ST_GAIN;
				ST_GAIN:  state_q <= ST_OUT;
				ST_OUT: begin
					// hold until the result register frees up
					if (out_load) begin
						wp_q <= wp_q + 1'b1;
						if (wp_q == {AB{1'b1}}) begin
							wrapped_q <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				dry_q   <= s_sample;
				win_q   <= wclamp[WB-1:0];
				mixed_q <= TB'($signed({s_sample, 8'h00}));
			end
			ST_DLY1: begin
				d_q    <= dprod[32 +: WB];
				fade_q <= FADE_ROM[phase_q[31 -: FB]];
			end
			ST_DLY2: begin
				pos1_q <= wp8 - d_q;
				d_q    <= dprod[32 +: WB];
			end
			ST_RA0:   pos2_q    <= wp8 - d_q;
			ST_RA1:   p_q       <= tap_sum;
			ST_RA2:   t1_q      <= tap_sum;
			ST_RA3:   p_q       <= tap_sum;
			ST_TAP2:  t2_q      <= tap_sum;
			ST_FADE1: x_q       <= mul_p;
			ST_FADE2: shifted_q <= acc_sh[TB-1:0];
			ST_MIX1:  x_q       <= mul_p;
			ST_MIX2:  mixed_q   <= acc_sh[TB-1:0];
			ST_GAIN:  res_q     <= acc_sh;
			ST_OUT: begin
				if (out_load) begin
					out_q <= sat[SAMPLE_BITS-1:0];
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_bypass_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !cfg.shift_enable) |=> $stable(phase_q))
		else $error("phase moved on a bypassed sample");

	a_wp_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (wp_q == AB'($past(wp_q) + 1'b1)))
		else $error("write pointer did not advance by one per result");

	a_wrap_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(wrapped_q))
		else $error("fill flag cleared outside reset");

	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_OUT))
		else $error("result raised outside the output step");
`endif

endmodule

### tb/delay_line_pitch_shifter_test.sv
module delay_line_pitch_shifter_test;
	import dlps_pkg::*;

	// Predicts each output sample from the accepted input samples and the register
	// settings, and holds the predictions until the block delivers them in order.
	class shift_scoreboard;
		logic [SampleBits-1:0] expected_q[$];
		int                    errors;
		int                    checked;
		longint                history[DelayDepth];
		int unsigned           wr_ptr;
		bit [31:0]             phase;
		bit [PincBits-1:0]     pinc;
		bit [WinBits-1:0]      win;
		bit                    up;
		bit                    en;
		bit [MixBits-1:0]      mix;
		bit [GainBits-1:0]     gain;
		longint unsigned       fade[FadeEntries];

		function new();
			longint unsigned one, x, a, a2, t, s, v;
			one = 64'd1 << 30;
			for (int i = 0; i < FadeEntries; i++) begin
				x  = (i <= FadeEntries - i) ? i : FadeEntries - i;
				a  = (64'd3373259426 * x) / FadeEntries;
				a2 = (a * a) >> 30;
				t  = one - a2 / 110;
				t  = one - ((a2 * t) >> 30) / 72;
				t  = one - ((a2 * t) >> 30) / 42;
				t  = one - ((a2 * t) >> 30) / 20;
				t  = one - ((a2 * t) >> 30) / 6;
				s  = (a * t) >> 30;
				if (s > one) begin
					s = one;
				end
				v = (s * s + (64'd1 << 44)) >> 45;
				fade[i] = (v > 32768) ? 32768 : v;
			end
			foreach (history[i]) history[i] = 0;
			wr_ptr = 0;
			phase  = 0;
			pinc   = 0;
			win    = 552960;
			up     = 1;
			en     = 0;
			mix    = 32768;
			gain   = 4096;
			errors = 0;
			checked = 0;
		endfunction

		function void set_reg(int idx, bit [31:0] v);
			case (idx)
				REG_PINC: pinc = v[PincBits-1:0];
				REG_WIN:  win  = v[WinBits-1:0];
				REG_UP:   up   = v[0];
				REG_EN:   en   = v[0];
				REG_MIX:  mix  = v[MixBits-1:0];
				REG_GAIN: gain = v[GainBits-1:0];
				default:  ;
			endcase
		endfunction

		function longint round_q(longint v, int n);
			return (v + (64'sd1 << (n - 1))) >>> n;
		endfunction

		// interpolated read at a delay with 8 fraction bits
		function longint tap_value(longint unsigned d);
			longint unsigned total, pos, i0, i1;
			longint          fr;
			total = DelayDepth * 256;
			pos   = (longint'(wr_ptr) * 256 + total - (d % total)) % total;
			i0    = (pos >> 8) % DelayDepth;
			i1    = (i0 + 1) % DelayDepth;
			fr    = pos & 255;
			return history[i0] * (256 - fr) + history[i1] * fr;
		endfunction

		function longint unsigned grain_delay(bit [31:0] ph, longint unsigned w);
			longint unsigned f;
			f = up ? ((64'd1 << 32) - ph) : longint'(ph);
			return (f * w) >> 32;
		endfunction

		function void note_sample(logic [SampleBits-1:0] raw);
			longint          dry, t1, t2, shifted, mixed, res, m, fd;
			longint unsigned w;
			bit [31:0]       ph2;
			dry = longint'($signed(raw));
			history[wr_ptr] = dry;
			if (en) begin
				phase = phase + {{(32-PincBits){pinc[PincBits-1]}}, pinc};
				w = win;
				if (w < 32 * 256) w = 32 * 256;
				if (w > (DelayDepth - 4) * 256) w = (DelayDepth - 4) * 256;
				ph2 = phase + 32'h8000_0000;
				t1  = tap_value(grain_delay(phase, w));
				t2  = tap_value(grain_delay(ph2, w));
				fd  = fade[phase[31:22]];
				shifted = round_q(t1 * (32768 - fd) + t2 * fd, 15);
				m = (mix > 32768) ? 32768 : mix;
				mixed = round_q(dry * 256 * (32768 - m) + shifted * m, 15);
			end else begin
				mixed = dry * 256;
			end
			res = round_q(mixed * longint'(gain), 20);
			if (res > 64'sd8388607) res = 64'sd8388607;
			if (res < -64'sd8388608) res = -64'sd8388608;
			expected_q.push_back(res[SampleBits-1:0]);
			wr_ptr = (wr_ptr + 1) % DelayDepth;
		endfunction

		function void check_sample(logic [SampleBits-1:0] actual);
			logic [SampleBits-1:0] want;
			checked++;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected output sample, expected none, actual %0d",
					$time, $signed(actual));
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (actual !== want) begin
				$display("%0t: sample_out mismatch, expected %0d, actual %0d",
					$time, $signed(want), $signed(actual));
				errors++;
			end
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     s_tvalid;
	logic                     s_tready;
	logic [23:0]              s_tdata;   // [23:0] sample_in
	logic                     m_tvalid;
	logic                     m_tready;
	logic [23:0]              m_tdata;   // [23:0] sample_out
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [CfgAddrBits-1:0]   paddr;
	logic [CfgDataBits-1:0]   pwdata;
	logic [CfgDataBits-1:0]   prdata;
	logic                     pready;

	shift_scoreboard sb;
	int  idle_mode;      // 0 none, 1 sender idles, 2 receiver stalls, 3 both lightly
	int  quiet_cycles;
	int  sent;
	bit  timed_out;

	delay_line_pitch_shifter dut (.*);

	always #5 clk = ~clk;

	// Drain the sink side; stall according to the current idling mode.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_sample(m_tdata[23:0]);
		end
		case (idle_mode)
			2:       m_tready <= ($urandom_range(0, 99) >= 73);
			3:       m_tready <= ($urandom_range(0, 99) >= 13);
			default: m_tready <= 1'b1;
		endcase
	end

	// Watchdog: count cycles where no beat moves on either side and no APB access is under way.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles > 5000 && !timed_out) begin
			timed_out = 1;
			$display("simulation failed");
			$finish;
		end
	end

	// APB write with a setup and an access phase; the register takes it at the access edge.
	task automatic reg_write(int idx, bit [31:0] v);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CfgAddrBits'(idx * 4);
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		sb.set_reg(idx, v);
	endtask

	// Present one sample, with an optional idle gap first; hold it until accepted.
	task automatic send_sample(logic [23:0] v);
		if ((idle_mode == 1 && $urandom_range(0, 99) < 73) ||
		    (idle_mode == 3 && $urandom_range(0, 99) < 13)) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 24'($urandom);
			@(posedge clk);
			while ((idle_mode == 1 && $urandom_range(0, 99) < 73) ||
			       (idle_mode == 3 && $urandom_range(0, 99) < 13)) begin
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		do @(posedge clk); while (!s_tready);
		sb.note_sample(v);
		sent++;
	endtask

	// Hold off until every prediction has arrived, then let the pipeline empty.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [23:0] pick_sample();
		case ($urandom_range(0, 9))
			0:       return 24'h7FFFFF;
			1:       return 24'h800000;
			2:       return 24'($urandom_range(0, 3) - 2);
			default: return 24'($urandom);
		endcase
	endfunction

	initial begin
		sb = new();
		clk       = 1'b0;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		m_tready  <= 1'b1;
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		paddr     <= '0;
		pwdata    <= '0;
		idle_mode = 0;
		quiet_cycles = 0;
		sent = 0;
		timed_out = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Bypass at reset settings: extremes, then saturating and zero gain.
		send_sample(24'h7FFFFF);
		send_sample(24'h800000);
		send_sample(24'h000000);
		send_sample(24'hFFFFFF);
		send_sample(24'h000001);
		drain();
		reg_write(REG_GAIN, 32767);
		reg_write(REG_MIX, 0);
		send_sample(24'h7FFFFF);
		send_sample(24'h800000);
		send_sample(24'h123456);
		drain();
		reg_write(REG_GAIN, 0);
		send_sample(24'h7FFFFF);
		drain();

		// Shift up, shortest window (below the clamp), fully wet.
		reg_write(REG_GAIN, 4096);
		reg_write(REG_MIX, 32768);
		reg_write(REG_EN, 1);
		reg_write(REG_UP, 1);
		reg_write(REG_WIN, 0);
		reg_write(REG_PINC, 32'h0FFF_FFFF);
		repeat (6) send_sample(pick_sample());
		drain();
		// Shift down, window above the clamp, mix past full scale, fastest wrap down.
		reg_write(REG_UP, 0);
		reg_write(REG_WIN, 32'h1F_FFFF);
		reg_write(REG_MIX, 32'hFFFF);
		reg_write(REG_PINC, 32'h1000_0000);
		reg_write(6, 32'hFFFF_FFFF);   // unmapped index, must be ignored
		reg_write(7, 32'h0);
		repeat (6) send_sample(pick_sample());
		drain();

		// Random phases, cycling the idling modes.
		for (int p = 0; p < 8; p++) begin
			idle_mode = p % 4;
			reg_write(REG_PINC, ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 4095));
			reg_write(REG_WIN, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(8192, 65536));
			reg_write(REG_UP, $urandom_range(0, 1));
			reg_write(REG_EN, 32'($urandom_range(0, 5) != 0));
			reg_write(REG_MIX, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32768));
			reg_write(REG_GAIN, ($urandom_range(0, 1)) ? $urandom : $urandom_range(2048, 8192));
			repeat (216) send_sample(pick_sample());
			drain();
		end
		idle_mode = 0;
		repeat (20) @(posedge clk);

		$display("Sent %0d samples over bypass, shift up and shift down settings,", sent);
		$display("checked %0d output samples under four idling patterns.", sb.checked);
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

### files.f
sv/dlps_pkg.sv
sv/dlps_ram.sv
sv/dlps_cfg.sv
sv/delay_line_pitch_shifter.sv
tb/delay_line_pitch_shifter_test.sv
